/* rtl/core/interrupt_table_record_parser_top_macros.svh */
// Assertion macros used by the interrupt table record parser checker.
`ifndef INTERRUPT_TABLE_RECORD_PARSER_TOP_MACROS_SVH
`define INTERRUPT_TABLE_RECORD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("itrp: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("itrp: next-cycle check failed");

`endif

/* rtl/core/itrp_pkg.sv */
// Types and constants of the interrupt table record parser.
package itrp_pkg;

	localparam int MAX_PROCESSORS     = 64;
	localparam int MAX_IO_CONTROLLERS = 16;
	localparam int REC_KEEP           = 16;
	localparam int REC_IDX_W          = $clog2(REC_KEEP);
	localparam int PROC_CNT_W         = $clog2(MAX_PROCESSORS + 1);
	localparam int IO_CNT_W           = $clog2(MAX_IO_CONTROLLERS + 1);
	localparam int SLOT_W             = 6;
	localparam int HDR_LAST_POS       = 7;
	localparam int HDR_ADDR_BYTES     = 4;
	localparam int HDR_FLAGS_POS      = 4;
	localparam int MIN_REC_LEN        = 2;
	localparam int LEGACY_IRQS        = 16;

	// Record type codes as found in the table
	localparam logic [7:0] REC_PROCESSOR     = 8'd0;
	localparam logic [7:0] REC_IO_CTRL       = 8'd1;
	localparam logic [7:0] REC_IRQ_OVERRIDE  = 8'd2;
	localparam logic [7:0] REC_ADDR_OVERRIDE = 8'd5;
	localparam logic [7:0] REC_X2_PROCESSOR  = 8'd9;

	typedef enum logic [2:0] {
		KIND_HEADER       = 3'd0,
		KIND_PROCESSOR    = 3'd1,
		KIND_IO_CTRL      = 3'd2,
		KIND_IRQ_OVERRIDE = 3'd3,
		KIND_ADDR_OVERRIDE = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        ident_a;
		logic [31:0]        ident_b;
		logic [63:0]        address;
		logic [31:0]        gsi;
		logic               pol_low;
		logic               trig_level;
		logic               pcat_compat;
		logic [SLOT_W-1:0]  slot;
	} record_t;

endpackage

/* rtl/core/itrp_if.sv */
// Stream interfaces of the interrupt table record parser: table bytes and records.
interface itrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	logic       last;

	modport source (output valid, output data_byte, output first, output last, input ready);
	modport sink (input valid, input data_byte, input first, input last, output ready);
endinterface

interface itrp_record_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] ident_a;
	logic [31:0] ident_b;
	logic [63:0] address;
	logic [31:0] gsi;
	logic        pol_low;
	logic        trig_level;
	logic        pcat_compat;
	logic [5:0]  slot;

	modport source (output valid, output kind, output ident_a, output ident_b, output address,
		output gsi, output pol_low, output trig_level, output pcat_compat,
		output slot, input ready);
	modport sink (input valid, input kind, input ident_a, input ident_b, input address,
		input gsi, input pol_low, input trig_level, input pcat_compat,
		input slot, output ready);
endinterface

/* rtl/core/interrupt_table_record_parser_top.sv */
// Interrupt table record parser: byte stream of the table body in, decoded records out.
//
// The block takes the body of an interrupt controller description table, one byte per
// transfer, starting right after the common 36-byte header; a byte flagged first restarts
// the parse and clears all state, counts included. The first eight bytes give the local
// controller address and the flags word, and a header record leaves after the eighth.
// Every following type/length record is gathered and, on its last declared byte, turned
// into a processor, I/O controller, IRQ override or local address override record. Bytes
// beyond the sixteenth of a record are consumed but not kept; offsets past a record's
// declared length read as zero. A length byte below two, or the byte flagged last, stops
// the parse until the next first byte, and a record cut off by the end is dropped.
// Processor and I/O controller records get consecutive slots until 64 and 16 of them have
// been handed out; later ones, disabled processors, overrides for IRQ 16 and up and
// unknown types produce nothing. Filling the identity IRQ table is up to the consumer.
// Rate: one byte per clock while the output is not stalled. A byte is held in the input
// register, where the state update and record decode run, and its record (if any) is
// loaded into the output register when the byte advances. The output register decouples
// the two sides: the input register can still take a byte while a record waits, and the
// input stalls once that register also holds a byte behind a waiting record.
module interrupt_table_record_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	itrp_byte_if.sink            table_bytes,
	itrp_record_if.source        records
);

	localparam int KEEP = itrp_pkg::REC_KEEP;
	localparam int IDXW = itrp_pkg::REC_IDX_W;
	localparam int PCW  = itrp_pkg::PROC_CNT_W;
	localparam int ICW  = itrp_pkg::IO_CNT_W;

	// Input register
	itrp_pkg::byte_item_t item_s1;
	logic                 valid_s1;
	logic                 advance;

	// Parse state
	logic [31:0]          hdr_addr_q;
	logic                 legacy_q;
	logic [7:0]           rec_q [KEEP];
	logic [7:0]           pos_q;
	logic [7:0]           len_q;
	logic                 in_header_q;
	logic                 halted_q;
	logic [PCW-1:0]       proc_cnt_q;
	logic [ICW-1:0]       io_cnt_q;

	// Next state and decode
	logic [31:0]          hdr_addr_d;
	logic                 legacy_d;
	logic [7:0]           rec_d [KEEP];
	logic [7:0]           pos_st;
	logic [7:0]           pos_d;
	logic [7:0]           len_d;
	logic                 in_header_st;
	logic                 in_header_d;
	logic                 halted_st;
	logic                 halted_d;
	logic [PCW-1:0]       proc_cnt_st;
	logic [PCW-1:0]       proc_cnt_d;
	logic [ICW-1:0]       io_cnt_st;
	logic [ICW-1:0]       io_cnt_d;
	logic                 short_len;
	logic                 rec_done;
	logic                 proc_full;
	logic                 io_full;
	logic                 res_valid;
	itrp_pkg::record_t    res;

	// Output register
	logic                 rec_valid_q;
	itrp_pkg::record_t    rec_out_q;

	// Process the held byte only when the output register is free or being taken, whether or not the byte makes a record.
	assign advance           = valid_s1 && (!rec_valid_q || records.ready);
	assign table_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (table_bytes.ready) begin
			valid_s1 <= table_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (table_bytes.valid && table_bytes.ready) begin
			item_s1 <= '{data_byte: table_bytes.data_byte, first: table_bytes.first,
				last: table_bytes.last};
		end
	end

	always_comb begin
		// A first byte sees reset state; header and record bytes are rewritten before use.
		pos_st       = item_s1.first ? 8'd0 : pos_q;
		in_header_st = item_s1.first ? 1'b1 : in_header_q;
		halted_st    = item_s1.first ? 1'b0 : halted_q;
		proc_cnt_st  = item_s1.first ? '0 : proc_cnt_q;
		io_cnt_st    = item_s1.first ? '0 : io_cnt_q;

		hdr_addr_d  = hdr_addr_q;
		legacy_d    = legacy_q;
		rec_d       = rec_q;
		pos_d       = pos_st;
		len_d       = item_s1.first ? 8'd0 : len_q;
		in_header_d = in_header_st;
		halted_d    = halted_st;
		proc_cnt_d  = proc_cnt_st;
		io_cnt_d    = io_cnt_st;
		short_len   = 1'b0;
		rec_done    = 1'b0;
		res_valid   = 1'b0;
		res         = '0;

		proc_full = proc_cnt_st >= PCW'(itrp_pkg::MAX_PROCESSORS);
		io_full   = io_cnt_st >= ICW'(itrp_pkg::MAX_IO_CONTROLLERS);

		if (!halted_st) begin
			if (in_header_st) begin
				if (pos_st < 8'(itrp_pkg::HDR_ADDR_BYTES)) begin
					hdr_addr_d[{pos_st[1:0], 3'b000} +: 8] = item_s1.data_byte;
				end
				if (pos_st == 8'(itrp_pkg::HDR_FLAGS_POS)) begin
					legacy_d = item_s1.data_byte[0];
				end
				if (pos_st >= 8'(itrp_pkg::HDR_LAST_POS)) begin
					res_valid       = 1'b1;
					res.kind        = itrp_pkg::KIND_HEADER;
					res.address     = {32'd0, hdr_addr_d};
					res.pcat_compat = legacy_d;
					in_header_d     = 1'b0;
					pos_d           = 8'd0;
				end else begin
					pos_d = pos_st + 8'd1;
				end
			end else begin
				// Gather the record; a new one starts from zeros.
				if (pos_st == 8'd0) begin
					for (int i = 0; i < KEEP; i++) begin
						rec_d[i] = 8'd0;
					end
					rec_d[0] = item_s1.data_byte;
				end else if (pos_st < 8'(KEEP)) begin
					rec_d[pos_st[IDXW-1:0]] = item_s1.data_byte;
				end
				if (pos_st == 8'd1) begin
					len_d = item_s1.data_byte;
					if (item_s1.data_byte < 8'(itrp_pkg::MIN_REC_LEN)) begin
						short_len = 1'b1;
						halted_d  = 1'b1;
					end
				end
				if (!short_len) begin
					rec_done = (pos_st != 8'd0) && ({1'b0, pos_st} + 9'd1 == {1'b0, len_d});
					pos_d    = rec_done ? 8'd0 : pos_st + 8'd1;
				end
				if (rec_done) begin
					case (rec_d[0])
						itrp_pkg::REC_PROCESSOR: begin
							if (rec_d[4][1:0] != 2'b00 && !proc_full) begin
								res_valid   = 1'b1;
								res.kind    = itrp_pkg::KIND_PROCESSOR;
								res.ident_a = {24'd0, rec_d[3]};
								res.ident_b = {24'd0, rec_d[2]};
								res.slot    = itrp_pkg::SLOT_W'(proc_cnt_st);
								proc_cnt_d  = proc_cnt_st + PCW'(1);
							end
						end
						itrp_pkg::REC_X2_PROCESSOR: begin
							if (rec_d[8][1:0] != 2'b00 && !proc_full) begin
								res_valid   = 1'b1;
								res.kind    = itrp_pkg::KIND_PROCESSOR;
								res.ident_a = {rec_d[7], rec_d[6], rec_d[5], rec_d[4]};
								res.ident_b = {rec_d[15], rec_d[14], rec_d[13], rec_d[12]};
								res.slot    = itrp_pkg::SLOT_W'(proc_cnt_st);
								proc_cnt_d  = proc_cnt_st + PCW'(1);
							end
						end
						itrp_pkg::REC_IO_CTRL: begin
							if (!io_full) begin
								res_valid   = 1'b1;
								res.kind    = itrp_pkg::KIND_IO_CTRL;
								res.ident_a = {24'd0, rec_d[2]};
								res.address = {32'd0, rec_d[7], rec_d[6], rec_d[5], rec_d[4]};
								res.gsi     = {rec_d[11], rec_d[10], rec_d[9], rec_d[8]};
								res.slot    = itrp_pkg::SLOT_W'(io_cnt_st);
								io_cnt_d    = io_cnt_st + ICW'(1);
							end
						end
						itrp_pkg::REC_IRQ_OVERRIDE: begin
							if (rec_d[3] < 8'(itrp_pkg::LEGACY_IRQS)) begin
								res_valid      = 1'b1;
								res.kind       = itrp_pkg::KIND_IRQ_OVERRIDE;
								res.ident_a    = {24'd0, rec_d[3]};
								res.gsi        = {rec_d[7], rec_d[6], rec_d[5], rec_d[4]};
								res.pol_low    = rec_d[8][1:0] == 2'b11;
								res.trig_level = rec_d[8][3:2] == 2'b11;
							end
						end
						itrp_pkg::REC_ADDR_OVERRIDE: begin
							res_valid   = 1'b1;
							res.kind    = itrp_pkg::KIND_ADDR_OVERRIDE;
							res.address = {rec_d[11], rec_d[10], rec_d[9], rec_d[8],
								rec_d[7], rec_d[6], rec_d[5], rec_d[4]};
						end
						default: begin
							res_valid = 1'b0;
						end
					endcase
				end
			end
			// The last byte stops the parse; an unfinished record is simply dropped.
			if (item_s1.last) begin
				halted_d = 1'b1;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 8'd0;
			len_q       <= 8'd0;
			in_header_q <= 1'b1;
			halted_q    <= 1'b0;
			proc_cnt_q  <= '0;
			io_cnt_q    <= '0;
		end else if (advance) begin
			pos_q       <= pos_d;
			len_q       <= len_d;
			in_header_q <= in_header_d;
			halted_q    <= halted_d;
			proc_cnt_q  <= proc_cnt_d;
			io_cnt_q    <= io_cnt_d;
		end
	end

	// Header and record bytes: always rewritten before they are read
	always_ff @(posedge clk) begin
		if (advance) begin
			hdr_addr_q <= hdr_addr_d;
			legacy_q   <= legacy_d;
			rec_q      <= rec_d;
		end
	end

	// Output register: drop the record once taken, load a new one when it is made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			rec_valid_q <= 1'b1;
		end else if (records.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			rec_out_q <= res;
		end
	end

	assign records.valid       = rec_valid_q;
	assign records.kind        = rec_out_q.kind;
	assign records.ident_a     = rec_out_q.ident_a;
	assign records.ident_b     = rec_out_q.ident_b;
	assign records.address     = rec_out_q.address;
	assign records.gsi         = rec_out_q.gsi;
	assign records.pol_low     = rec_out_q.pol_low;
	assign records.trig_level  = rec_out_q.trig_level;
	assign records.pcat_compat = rec_out_q.pcat_compat;
	assign records.slot        = rec_out_q.slot;

endmodule

/* rtl/core/itrp_checker.sv */
// Port-level checker for the interrupt table record parser, bound to its top level.
`include "interrupt_table_record_parser_top_macros.svh"

module itrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [31:0] ident_a,
	input logic [31:0] ident_b,
	input logic [63:0] address,
	input logic [31:0] gsi,
	input logic [5:0]  slot
);

	logic         out_stall;
	logic [168:0] rec_bits;
	logic         is_header;
	logic         is_override;
	logic         hdr_clean;
	logic         ovr_clean;

	assign out_stall   = out_valid && !out_ready;
	assign rec_bits    = {kind, ident_a, ident_b, address, gsi, slot};
	assign is_header   = out_valid && (kind == itrp_pkg::KIND_HEADER);
	assign is_override = out_valid && (kind == itrp_pkg::KIND_IRQ_OVERRIDE);
	assign hdr_clean   = (ident_a == 32'd0) && (ident_b == 32'd0) && (gsi == 32'd0) &&
		(slot == 6'd0) && (address[63:32] == 32'd0);
	assign ovr_clean   = (ident_a < 32'(itrp_pkg::LEGACY_IRQS)) && (address == 64'd0) &&
		(ident_b == 32'd0);

	// A stalled record holds
	`ITRP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(rec_bits))

	// Input backpressure only comes from a record waiting at the output
	`ITRP_ASSERT_IMPL(a_ready_cause, clk, arst_n, !in_ready, out_stall)

	// Header records carry only the 32-bit address and the flag
	`ITRP_ASSERT_IMPL(a_header_fields, clk, arst_n, is_header, hdr_clean)

	// Overrides are only passed on for legacy IRQs
	`ITRP_ASSERT_IMPL(a_override_fields, clk, arst_n, is_override, ovr_clean)

endmodule

bind interrupt_table_record_parser_top itrp_checker u_itrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (table_bytes.ready),
	.out_valid (records.valid),
	.out_ready (records.ready),
	.kind      (records.kind),
	.ident_a   (records.ident_a),
	.ident_b   (records.ident_b),
	.address   (records.address),
	.gsi       (records.gsi),
	.slot      (records.slot)
);

/* tb/itrp_tb_pkg.sv */
// Record predictor and checker for the interrupt table record parser testbench.
`timescale 1ns / 1ps
package itrp_tb_pkg;
	import itrp_pkg::*;

	class record_scoreboard;
		logic [63:0] hdr_bytes;
		logic [7:0]  rec_buf [REC_KEEP];
		logic [7:0]  offset;
		logic [7:0]  rec_len;
		bit          in_hdr;
		bit          stopped;
		int unsigned proc_count;
		int unsigned io_count;
		record_t     expected_records [$];
		int unsigned mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			hdr_bytes = '0;
			foreach (rec_buf[i]) rec_buf[i] = '0;
			offset     = '0;
			rec_len    = '0;
			in_hdr     = 1'b1;
			stopped    = 1'b0;
			proc_count = 0;
			io_count   = 0;
		endfunction

		// Little-endian field of the current record; bytes not kept read as zero.
		function logic [63:0] rec_le(int unsigned off, int unsigned n);
			logic [63:0] v;
			v = '0;
			for (int unsigned i = 0; i < n; i++)
				if (off + i < REC_KEEP) v[8*i +: 8] = rec_buf[off + i];
			return v;
		endfunction

		function void decode_record();
			record_t r;
			r = '0;
			case (rec_buf[0])
				REC_PROCESSOR: begin
					if (rec_buf[4][1:0] == 2'b00 || proc_count >= MAX_PROCESSORS) return;
					r.kind    = KIND_PROCESSOR;
					r.ident_a = {24'h0, rec_buf[3]};
					r.ident_b = {24'h0, rec_buf[2]};
					r.slot    = proc_count[SLOT_W-1:0];
					proc_count++;
				end
				REC_X2_PROCESSOR: begin
					if (rec_buf[8][1:0] == 2'b00 || proc_count >= MAX_PROCESSORS) return;
					r.kind    = KIND_PROCESSOR;
					r.ident_a = 32'(rec_le(4, 4));
					r.ident_b = 32'(rec_le(12, 4));
					r.slot    = proc_count[SLOT_W-1:0];
					proc_count++;
				end
				REC_IO_CTRL: begin
					if (io_count >= MAX_IO_CONTROLLERS) return;
					r.kind    = KIND_IO_CTRL;
					r.ident_a = {24'h0, rec_buf[2]};
					r.address = {32'h0, 32'(rec_le(4, 4))};
					r.gsi     = 32'(rec_le(8, 4));
					r.slot    = io_count[SLOT_W-1:0];
					io_count++;
				end
				REC_IRQ_OVERRIDE: begin
					if (rec_buf[3] >= LEGACY_IRQS) return;
					r.kind       = KIND_IRQ_OVERRIDE;
					r.ident_a    = {24'h0, rec_buf[3]};
					r.gsi        = 32'(rec_le(4, 4));
					r.pol_low    = (rec_buf[8][1:0] == 2'b11);
					r.trig_level = (rec_buf[8][3:2] == 2'b11);
				end
				REC_ADDR_OVERRIDE: begin
					r.kind    = KIND_ADDR_OVERRIDE;
					r.address = rec_le(4, 8);
				end
				default: return;
			endcase
			expected_records.push_back(r);
		endfunction

		// Advance the parse by one accepted byte and queue any record it completes.
		function void note_byte(byte_item_t b);
			record_t r;
			if (b.first) restart();
			if (stopped) return;
			if (in_hdr) begin
				hdr_bytes[8*offset[2:0] +: 8] = b.data_byte;
				if (offset >= HDR_LAST_POS) begin
					r             = '0;
					r.kind        = KIND_HEADER;
					r.address     = {32'h0, hdr_bytes[31:0]};
					r.pcat_compat = hdr_bytes[32];
					expected_records.push_back(r);
					in_hdr = 1'b0;
					offset = '0;
				end else begin
					offset++;
				end
			end else begin
				if (offset == 0) foreach (rec_buf[i]) rec_buf[i] = '0;
				if (offset < REC_KEEP) rec_buf[offset] = b.data_byte;
				if (offset == 1) begin
					rec_len = b.data_byte;
					if (b.data_byte < MIN_REC_LEN) begin
						stopped = 1'b1;
						return;
					end
				end
				if (offset >= 1 && int'(offset) + 1 == int'(rec_len)) begin
					decode_record();
					offset = '0;
				end else begin
					offset++;
				end
			end
			if (b.last) stopped = 1'b1;
		endfunction

		function void check_record(record_t got);
			record_t want;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: record with none due: kind %0d a %h b %h addr %h gsi %h slot %0d",
						$time, got.kind, got.ident_a, got.ident_b, got.address, got.gsi, got.slot);
				return;
			end
			want = expected_records.pop_front();
			if (got.kind !== want.kind || got.ident_a !== want.ident_a ||
					got.ident_b !== want.ident_b || got.address !== want.address ||
					got.gsi !== want.gsi || got.pol_low !== want.pol_low ||
					got.trig_level !== want.trig_level ||
					got.pcat_compat !== want.pcat_compat || got.slot !== want.slot) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: record mismatch, expected kind %0d a %h b %h addr %h gsi %h",
						$time, want.kind, want.ident_a, want.ident_b, want.address, want.gsi);
					$display("    pl %b tl %b pc %b slot %0d; got kind %0d a %h b %h addr %h",
						want.pol_low, want.trig_level, want.pcat_compat, want.slot,
						got.kind, got.ident_a, got.ident_b, got.address);
					$display("    gsi %h pl %b tl %b pc %b slot %0d", got.gsi, got.pol_low,
						got.trig_level, got.pcat_compat, got.slot);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_records.size();
		endfunction
	endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench of the interrupt table record parser: stimulus, handshakes and checking.
`timescale 1ns / 1ps
module tb_top;
	import itrp_pkg::*;
	import itrp_tb_pkg::*;

	// Cycles without any transfer before the run is declared hung. The longest correct
	// quiet stretch is the receiver hold-off below plus a short idle gap.
	localparam int unsigned QUIET_LIMIT     = 4000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned HOLD_OFF_AT     = 1000;
	localparam int unsigned PHASE_LEN       = 160;
	localparam int unsigned STREAM_BYTES    = 1950;
	localparam int unsigned DRAIN_CYCLES    = 16;

	typedef enum int unsigned {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_phase_t;

	logic clk;
	logic arst_n;

	itrp_byte_if   table_bytes ();
	itrp_record_if records ();

	interrupt_table_record_parser_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.table_bytes (table_bytes),
		.records     (records)
	);

	record_scoreboard sb;
	byte_item_t       table_stream [$];
	int unsigned      bytes_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle percentage for one side; the phase steps through the four patterns as bytes go by.
	function automatic int unsigned idle_pct(bit sender_side);
		idle_phase_t ph;
		ph = idle_phase_t'((bytes_sent / PHASE_LEN) % 4);
		case (ph)
			IDLE_SENDER:   return sender_side ? 46 : 0;
			IDLE_RECEIVER: return sender_side ? 0 : 46;
			IDLE_BOTH:     return 15;
			default:       return 0;
		endcase
	endfunction

	function automatic bit roll(int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// ---------------------------------------------------------------- stream building

	function automatic void put(logic [7:0] d, bit f = 1'b0, bit l = 1'b0);
		byte_item_t it;
		it.data_byte = d;
		it.first     = f;
		it.last      = l;
		table_stream.push_back(it);
	endfunction

	// Flag the byte queued most recently as the end of its table.
	function automatic void end_table();
		table_stream[table_stream.size() - 1].last = 1'b1;
	endfunction

	// Eight header bytes; the first one restarts the parse.
	function automatic void put_header(logic [31:0] addr, logic [31:0] flags);
		for (int i = 0; i < 4; i++) put(addr[8*i +: 8], i == 0);
		for (int i = 0; i < 4; i++) put(flags[8*i +: 8]);
	endfunction

	// One type/length record with random content. Steer the fields that gate a result
	// so that enabled processors and legacy IRQs dominate without excluding the rest.
	function automatic void put_record(logic [7:0] typ, int unsigned len, bit enabled);
		logic [7:0] body [256];
		body[0] = typ;
		body[1] = len[7:0];
		for (int i = 2; i < 256; i++) body[i] = 8'($urandom_range(0, 255));
		if (typ == REC_PROCESSOR && (enabled || $urandom_range(0, 3) != 0))
			body[4][1:0] = 2'($urandom_range(1, 3));
		if (typ == REC_X2_PROCESSOR && (enabled || $urandom_range(0, 3) != 0))
			body[8][1:0] = 2'($urandom_range(1, 3));
		if (typ == REC_IRQ_OVERRIDE && $urandom_range(0, 9) < 7)
			body[3] = 8'($urandom_range(0, LEGACY_IRQS - 1));
		for (int unsigned i = 0; i < len; i++) put(body[i]);
	endfunction

	function automatic void put_random_record();
		logic [7:0]  typ;
		int unsigned len;
		case ($urandom_range(0, 9))
			0, 1:    begin typ = REC_PROCESSOR;     len = 8;  end
			2:       begin typ = REC_X2_PROCESSOR;  len = 16; end
			3, 4:    begin typ = REC_IO_CTRL;       len = 12; end
			5, 6:    begin typ = REC_IRQ_OVERRIDE;  len = 10; end
			7:       begin typ = REC_ADDR_OVERRIDE; len = 12; end
			default: begin typ = 8'($urandom_range(0, 255)); len = $urandom_range(2, 20); end
		endcase
		// Short and long records: lengths that truncate fields or exceed the kept bytes
		if ($urandom_range(0, 4) == 0) len = $urandom_range(2, 40);
		put_record(typ, len, 1'b0);
	endfunction

	// One table: mostly well formed with random content, the rest broken in various ways.
	function automatic void put_table();
		int unsigned shape;
		int unsigned n;
		int unsigned len;
		shape = $urandom_range(0, 99);
		if (shape < 6) begin
			// noise with random restart and end marks
			n = $urandom_range(3, 10);
			repeat (n) put(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
				$urandom_range(0, 4) == 0);
			return;
		end
		if (shape < 12) begin
			// header cut off by the end of the table
			n = $urandom_range(1, 7);
			put(8'($urandom_range(0, 255)), 1'b1);
			repeat (n - 1) put(8'($urandom_range(0, 255)));
			end_table();
			return;
		end
		put_header($urandom, $urandom);
		n = $urandom_range(0, 8);
		repeat (n) put_random_record();
		if (shape < 20) begin
			// length byte below two, then bytes that must be ignored
			put(8'($urandom_range(0, 255)));
			put(8'($urandom_range(0, MIN_REC_LEN - 1)));
			repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
		end else if (shape < 28) begin
			// record cut off by the end of the table
			len = $urandom_range(3, 20);
			put(8'($urandom_range(0, 9)));
			put(len[7:0]);
			repeat ($urandom_range(0, len - 3)) put(8'($urandom_range(0, 255)));
		end else if (shape < 34) begin
			// no end mark: the next table restarts the parse mid-record
			repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
			return;
		end
		end_table();
		// trailing bytes after the end mark, with no restart
		if (shape >= 34 && shape < 40)
			repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)));
	endfunction

	// ---------------------------------------------------------------- driving

	// Drive the queued bytes, one transfer at a time, with random gaps.
	task automatic send_stream();
		byte_item_t item;
		while (table_stream.size() != 0) begin
			item = table_stream.pop_front();
			while (roll(idle_pct(1'b1))) begin
				table_bytes.valid <= 1'b0;
				@(negedge clk);
			end
			table_bytes.valid     <= 1'b1;
			table_bytes.data_byte <= item.data_byte;
			table_bytes.first     <= item.first;
			table_bytes.last      <= item.last;
			@(posedge clk);
			while (!table_bytes.ready) @(posedge clk);
			bytes_sent++;
			@(negedge clk);
		end
		table_bytes.valid <= 1'b0;
	endtask

	// Receiver: random stalls per phase, plus one long hold-off while the sender keeps
	// offering bytes, so the output register and then the input register fill up.
	initial begin : receiver
		int unsigned hold_left;
		bit          hold_done;
		hold_left     = 0;
		hold_done     = 1'b0;
		records.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && bytes_sent >= HOLD_OFF_AT) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				records.ready <= 1'b0;
			end else begin
				records.ready <= !roll(idle_pct(1'b0));
			end
		end
	end

	// Note every byte transfer in the predictor and check every record transfer.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (table_bytes.valid && table_bytes.ready)
				sb.note_byte(byte_item_t'({table_bytes.data_byte, table_bytes.first,
					table_bytes.last}));
			if (records.valid && records.ready)
				sb.check_record(record_t'({records.kind, records.ident_a, records.ident_b,
					records.address, records.gsi, records.pol_low,
					records.trig_level, records.pcat_compat, records.slot}));
		end
	end

	// Hang detection: too many cycles in a row with no transfer on either side.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (table_bytes.valid && table_bytes.ready) ||
					(records.valid && records.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("interrupt_table_record_parser_top regression: fail");
		$finish;
	end

	initial begin : main_seq
		sb                    = new();
		bytes_sent            = 0;
		arst_n                = 1'b0;
		table_bytes.valid     = 1'b0;
		table_bytes.data_byte = '0;
		table_bytes.first     = 1'b0;
		table_bytes.last      = 1'b0;

		// Directed: all-ones address with the legacy controller flag set, an override
		// for the highest legacy IRQ with both polarity and trigger fields at binary 11,
		// then a length byte of one that halts the parse, and a byte that must be dropped.
		put_header(32'hFFFF_FFFF, 32'h0000_0001);
		put(REC_IRQ_OVERRIDE);
		put(8'd10);
		put(8'h00);
		put(8'(LEGACY_IRQS - 1));
		repeat (4) put(8'hFF);
		put(8'h0F);
		put(8'h00);
		put(REC_PROCESSOR);
		put(8'd1);
		put(8'hFF);

		// A full table: more processors and I/O controllers than there are slots, with
		// short records mixed in so that missing bytes read as zero.
		put_header($urandom, $urandom);
		for (int i = 0; i < 70; i++) begin
			if (i % 4 == 3)
				put_record(REC_X2_PROCESSOR, $urandom_range(9, 16), 1'b1);
			else
				put_record(REC_PROCESSOR, $urandom_range(5, 8), i % 23 != 5);
		end
		for (int i = 0; i < 18; i++) put_record(REC_IO_CTRL, $urandom_range(3, 12), 1'b0);
		end_table();

		while (table_stream.size() < STREAM_BYTES) put_table();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_stream();

		// Drain: hold until every expected record has been seen, then give the block a
		// further drain period to show any record it should not produce.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (sb.mismatches == 0)
			$display("interrupt_table_record_parser_top regression: pass");
		else
			$display("interrupt_table_record_parser_top regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/itrp_pkg.sv
rtl/core/itrp_if.sv
rtl/core/interrupt_table_record_parser_top.sv
rtl/core/itrp_checker.sv
tb/itrp_tb_pkg.sv
tb/tb_top.sv
